[sv/pfc_pkg.sv]
`timescale 1ns / 1ps
// Package for the pitch format converter: format codes, register indexes, fixed-point
// constants and the log2 / exp2 lookup tables built at elaboration. No dependencies.
package pfc_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TABLE_BITS = 8;
  localparam int Q_BITS     = 30;
  localparam int ROM_W      = 32;
  localparam int TDEPTH     = 1 << TABLE_BITS;
  localparam int TSIZE      = TDEPTH + 1;
  localparam int TIDX_W     = TABLE_BITS + 1;
  localparam int REM_W      = Q_BITS - TABLE_BITS;
  localparam int PROD_W     = ROM_W + REM_W;
  localparam int MSB_W      = 5;
  localparam int D_W        = WORD_W + 2;
  localparam int N_W        = D_W - FRAC_BITS;
  localparam int L_W        = MSB_W + Q_BITS + 1;
  localparam int V_W        = L_W + 2;
  localparam int N3_W       = FRAC_BITS + 5;
  localparam int N50_W      = FRAC_BITS + 3;
  localparam int RECIP_SH   = 32;
  localparam int OCT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int NSTAGE     = 10;

  localparam logic [63:0] ONE_Q = 64'd1 << Q_BITS;

  localparam int PTO_MUL  = 25;
  localparam int PTO_DIV  = 3;
  localparam int OTP_MUL  = 6;
  localparam int OTP_BIAS = 25;
  localparam int OTP_DIV  = 50;

  localparam logic [RECIP_SH-1:0] RECIP3 =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(PTO_DIV) - 64'd1) / 64'(PTO_DIV));
  localparam logic [RECIP_SH-1:0] RECIP50 =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(OTP_DIV) - 64'd1) / 64'(OTP_DIV));

  localparam logic [WORD_W-1:0] REF_FREQ_RST = 32'd17144218;
  localparam logic [OCT_W-1:0]  REF_OCT_RST  = 4'd8;

  typedef enum logic [1:0] {
    FUNC_PITCH  = 2'd0,
    FUNC_OCTAVE = 2'd1,
    FUNC_FREQ   = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_FREQUENCY = 1'b0,
    REG_REF_OCTAVE    = 1'b1
  } cfg_reg_t;

  typedef logic [ROM_W-1:0] rom_t [TSIZE];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n   = n_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic rom_t build_log_rom();
    rom_t t;
    logic [63:0] x;
    logic [63:0] acc;
    for (int i = 0; i < TDEPTH; i++) begin
      x   = ONE_Q + (64'(i) << (Q_BITS - TABLE_BITS));
      acc = '0;
      for (int b = Q_BITS - 1; b >= 0; b--) begin
        x = (x * x + (ONE_Q >> 1)) >> Q_BITS;
        if (x >= 2 * ONE_Q) begin
          x      = x >> 1;
          acc[b] = 1'b1;
        end
      end
      t[i] = ROM_W'(acc);
    end
    t[TDEPTH] = ROM_W'(ONE_Q);
    return t;
  endfunction

  function automatic rom_t build_exp_rom();
    rom_t t;
    logic [63:0] root [TABLE_BITS+1];
    logic [63:0] v;
    logic [TIDX_W-1:0] iv;
    root[0] = 2 * ONE_Q;
    for (int k = 1; k <= TABLE_BITS; k++) begin
      root[k] = isqrt64(root[k-1] << Q_BITS);
    end
    for (int i = 0; i < TDEPTH; i++) begin
      iv = TIDX_W'(i);
      v  = ONE_Q;
      for (int k = 0; k < TABLE_BITS; k++) begin
        if (iv[TABLE_BITS-1-k]) begin
          v = (v * root[k+1] + (ONE_Q >> 1)) >> Q_BITS;
        end
      end
      t[i] = ROM_W'(v);
    end
    t[TDEPTH] = ROM_W'(2 * ONE_Q);
    return t;
  endfunction

  localparam rom_t LOG_ROM = build_log_rom();
  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

[sv/pitch_format_converter.sv]
`timescale 1ns / 1ps
// Pitch format converter top level: ten-stage pipeline converting between pitch,
// linear octave and frequency. Depends on pfc_pkg for constants and tables.
//
// Usage:
//   Input channel: in_valid / in_stall with in_func (0 pitch, 1 octave, 2 or 3
//   frequency) and in_value, unsigned Q16.16. A transaction completes when in_valid
//   is high and in_stall is low.
//   Result channel: out_valid / out_stall carrying all three forms plus the
//   saturated and invalid flags. One result per input transaction, in order.
//   Config channel: cfg_valid / cfg_ready, cfg_index 0 = reference frequency,
//   1 = reference octave. cfg_ready is always high; write only while idle.
//   Throughput: one transaction per cycle unless out_stall holds a valid result;
//   the ten register stages carry the log2 and exp2 table-interpolation datapaths.
//   Reset (rst_n low, synchronous) empties the pipeline and restores the reference
//   to 261.6 Hz at octave 8.
//   When out_stall holds a valid result, every stage holds and in_stall is raised;
//   nothing is dropped or repeated.
module pitch_format_converter
  import pfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [WORD_W-1:0]    in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_pitch_value,
  output logic [WORD_W-1:0]    out_octave_value,
  output logic [WORD_W-1:0]    out_frequency,
  output logic                 out_saturated,
  output logic                 out_invalid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  typedef struct packed {
    logic [1:0]              func;
    logic [WORD_W-1:0]       val;
    logic [WORD_W-1:0]       oct;
    logic                    sat;
    logic signed [N_W-1:0]   n;
  } ctx_t;

  typedef struct packed {
    logic [ROM_W-1:0] lo;
    logic [ROM_W-1:0] diff;
    logic             up;
    logic [REM_W-1:0] rem;
  } seg_t;

  typedef struct packed {
    logic [ROM_W-1:0]  lo;
    logic              up;
    logic [PROD_W-1:0] prod;
  } iprod_t;

  function automatic logic [MSB_W-1:0] msb_pos(input logic [WORD_W-1:0] r);
    logic [MSB_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (r[i]) m = MSB_W'(i);
    end
    return m;
  endfunction

  function automatic logic [Q_BITS-1:0] norm_frac(input logic [WORD_W-1:0] r,
                                                   input logic [MSB_W-1:0] m);
    logic [WORD_W-1:0] sh;
    sh = r << (MSB_W'(WORD_W - 1) - m);
    return sh[WORD_W-2 -: Q_BITS];
  endfunction

  function automatic seg_t seg_read(input logic use_log, input logic [Q_BITS-1:0] f);
    seg_t s;
    logic [TIDX_W-1:0] ix;
    logic [ROM_W-1:0]  hi;
    ix   = {1'b0, f[Q_BITS-1 -: TABLE_BITS]};
    s.lo = use_log ? LOG_ROM[ix] : EXP_ROM[ix];
    hi   = use_log ? LOG_ROM[ix + 1'b1] : EXP_ROM[ix + 1'b1];
    s.up = (hi >= s.lo);
    s.diff = s.up ? hi - s.lo : s.lo - hi;
    s.rem  = f[REM_W-1:0];
    return s;
  endfunction

  function automatic iprod_t seg_mul(input seg_t s);
    iprod_t p;
    p.lo   = s.lo;
    p.up   = s.up;
    p.prod = s.diff * s.rem;
    return p;
  endfunction

  function automatic logic [ROM_W-1:0] seg_done(input iprod_t p);
    logic [PROD_W:0]  t;
    logic [ROM_W-1:0] step;
    t    = {1'b0, p.prod} + ((PROD_W + 1)'(1) << (REM_W - 1));
    step = t[REM_W +: ROM_W];
    return p.up ? p.lo + step : p.lo - step;
  endfunction

  // configuration
  logic [WORD_W-1:0] ref_frequency_r;
  logic [OCT_W-1:0]  ref_octave_r;
  logic [WORD_W-1:0] ref_raw;

  // pipeline control
  logic [NSTAGE-1:0] vld_r;
  logic              adv;

  // stage payload
  ctx_t ctx1_r, ctx2_r, ctx3_r, ctx4_r, ctx5_r, ctx6_r, ctx7_r, ctx8_r, ctx9_r;
  ctx_t ctx1_nxt, ctx2_nxt, ctx3_nxt, ctx4_nxt, ctx5_nxt, ctx6_nxt, ctx7_nxt,
        ctx8_nxt, ctx9_nxt;

  logic [N3_W-1:0]  q3_r, q3_nxt;
  logic [MSB_W-1:0] msb2_r [2], msb2_nxt [2];
  logic [MSB_W-1:0] msb3_r [2], msb3_nxt [2];
  logic [MSB_W-1:0] msb4_r [2], msb4_nxt [2];
  logic [MSB_W-1:0] msb5_r [2], msb5_nxt [2];
  logic [Q_BITS-1:0] frac3_r [2], frac3_nxt [2];
  seg_t   lseg4_r [2], lseg4_nxt [2];
  iprod_t lprod5_r [2], lprod5_nxt [2];
  logic [L_W-1:0] lsum6_r [2], lsum6_nxt [2];
  logic signed [V_W-1:0] lv7_r, lv7_nxt;

  logic [FRAC_BITS-1:0] fr4_r, fr4_nxt;
  seg_t   eseg5_r, eseg5_nxt;
  iprod_t eprod6_r, eprod6_nxt;
  logic [ROM_W-1:0] mant7_r, mant7_nxt;
  logic [2*WORD_W-1:0] fprod8_r, fprod8_nxt;
  logic [WORD_W-1:0] fexp9_r, fexp9_nxt;
  logic [FRAC_BITS-1:0] q50_r, q50_nxt;

  logic [WORD_W-1:0] out_pitch_r, out_pitch_nxt;
  logic [WORD_W-1:0] out_oct_r, out_oct_nxt;
  logic [WORD_W-1:0] out_freq_r, out_freq_nxt;
  logic              out_sat_r, out_sat_nxt;
  logic              out_inv_r, out_inv_nxt;

  // combinational temporaries
  logic [WORD_W-1:0]      lsrc [2];
  logic [N3_W-1:0]        n3;
  logic [N3_W+RECIP_SH-1:0] p3;
  logic [WORD_W:0]        o_sum;
  logic signed [D_W-1:0]  d4;
  logic [Q_BITS-1:0]      f30;
  logic [ROM_W-1:0]       interp6;
  logic [V_W-1:0]         vr8;
  logic signed [N_W-1:0]  sh_full;
  logic [5:0]             sh;
  logic [2*WORD_W-1:0]    t9;
  logic [2*WORD_W-1:0]    big9;
  logic [4:0]             k5;
  logic                   sat_e;
  logic [N50_W-1:0]       n50;
  logic [N50_W+RECIP_SH-1:0] p50;
  logic                   f8_freq, f9_freq, f10_pitch, f10_freq;

  assign ref_raw   = (ref_frequency_r == '0) ? WORD_W'(1) : ref_frequency_r;
  assign cfg_ready = 1'b1;
  assign adv       = !vld_r[NSTAGE-1] || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_frequency_r <= REF_FREQ_RST;
      ref_octave_r    <= REF_OCT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REF_FREQUENCY: ref_frequency_r <= cfg_data;
        REG_REF_OCTAVE:    ref_octave_r    <= cfg_data[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  always_comb begin
    // stage 1: capture
    ctx1_nxt      = '0;
    ctx1_nxt.func = in_func;
    ctx1_nxt.val  = in_value;

    // stage 2: pitch fraction scaling, leading-one search
    ctx2_nxt = ctx1_r;
    n3       = N3_W'(ctx1_r.val[FRAC_BITS-1:0]) * N3_W'(PTO_MUL) + N3_W'(1);
    p3       = n3 * RECIP3;
    q3_nxt   = p3[RECIP_SH +: N3_W];
    lsrc[0]  = ctx1_r.val;
    lsrc[1]  = ref_raw;
    for (int i = 0; i < 2; i++) msb2_nxt[i] = msb_pos(lsrc[i]);

    // stage 3: octave for pitch and octave inputs, normalize for log2
    ctx3_nxt = ctx2_r;
    o_sum    = {1'b0, ctx2_r.val[WORD_W-1:FRAC_BITS], FRAC_BITS'(0)} + (WORD_W+1)'(q3_r);
    if (ctx2_r.func == FUNC_PITCH) begin
      ctx3_nxt.oct = o_sum[WORD_W] ? '1 : o_sum[WORD_W-1:0];
      ctx3_nxt.sat = o_sum[WORD_W];
    end else begin
      ctx3_nxt.oct = ctx2_r.val;
      ctx3_nxt.sat = 1'b0;
    end
    frac3_nxt[0] = norm_frac(ctx2_r.val, msb2_r[0]);
    frac3_nxt[1] = norm_frac(ref_raw, msb2_r[1]);
    for (int i = 0; i < 2; i++) msb3_nxt[i] = msb2_r[i];

    // stage 4: octave offset from reference, log2 table read
    ctx4_nxt   = ctx3_r;
    d4         = $signed({2'b00, ctx3_r.oct}) -
                 $signed(D_W'({ref_octave_r, FRAC_BITS'(0)}));
    ctx4_nxt.n = d4[D_W-1:FRAC_BITS];
    fr4_nxt    = d4[FRAC_BITS-1:0];
    for (int i = 0; i < 2; i++) begin
      lseg4_nxt[i] = seg_read(1'b1, frac3_r[i]);
      msb4_nxt[i]  = msb3_r[i];
    end

    // stage 5: exp2 table read, log2 slope product
    ctx5_nxt  = ctx4_r;
    f30       = {fr4_r, (Q_BITS - FRAC_BITS)'(0)};
    eseg5_nxt = seg_read(1'b0, f30);
    for (int i = 0; i < 2; i++) begin
      lprod5_nxt[i] = seg_mul(lseg4_r[i]);
      msb5_nxt[i]   = msb4_r[i];
    end

    // stage 6: exp2 slope product, log2 finish
    ctx6_nxt   = ctx5_r;
    eprod6_nxt = seg_mul(eseg5_r);
    for (int i = 0; i < 2; i++) begin
      interp6      = seg_done(lprod5_r[i]);
      lsum6_nxt[i] = {1'b0, msb5_r[i], Q_BITS'(0)} + L_W'(interp6);
    end

    // stage 7: exp2 mantissa, log2 difference
    ctx7_nxt  = ctx6_r;
    mant7_nxt = seg_done(eprod6_r);
    lv7_nxt   = $signed({2'b00, lsum6_r[0]}) - $signed({2'b00, lsum6_r[1]}) +
                $signed(V_W'({ref_octave_r, Q_BITS'(0)}));

    // stage 8: scale by reference, round log2 octave
    ctx8_nxt   = ctx7_r;
    fprod8_nxt = ref_raw * mant7_r;
    f8_freq    = (ctx7_r.func != FUNC_PITCH) && (ctx7_r.func != FUNC_OCTAVE);
    vr8        = lv7_r + V_W'(1 << (Q_BITS - FRAC_BITS - 1));
    if (f8_freq) begin
      if (lv7_r[V_W-1]) begin
        ctx8_nxt.oct = '0;
        ctx8_nxt.sat = 1'b1;
      end else begin
        ctx8_nxt.oct = WORD_W'(vr8[V_W-1:Q_BITS-FRAC_BITS]);
        ctx8_nxt.sat = 1'b0;
      end
    end

    // stage 9: power-of-two shift of frequency, octave to pitch scaling
    ctx9_nxt = ctx8_r;
    sh_full  = N_W'(Q_BITS - 1) - ctx8_r.n;
    sh       = sh_full[5:0];
    k5       = ctx8_r.n[4:0] - 5'(Q_BITS);
    t9       = fprod8_r >> sh;
    big9     = fprod8_r >> (6'(WORD_W) - {1'b0, k5});
    if (ctx8_r.n < N_W'(Q_BITS)) begin
      sat_e     = (t9 >= ((64'd1 << (WORD_W + 1)) - 64'd1));
      fexp9_nxt = sat_e ? '1 : t9[WORD_W:1] + WORD_W'(t9[0]);
    end else begin
      sat_e     = (ctx8_r.n >= N_W'(Q_BITS + WORD_W)) || (big9 != '0);
      fexp9_nxt = sat_e ? '1 : WORD_W'(fprod8_r << k5);
    end
    f9_freq = (ctx8_r.func != FUNC_PITCH) && (ctx8_r.func != FUNC_OCTAVE);
    if (!f9_freq) ctx9_nxt.sat = ctx8_r.sat | sat_e;
    n50     = N50_W'(ctx8_r.oct[FRAC_BITS-1:0]) * N50_W'(OTP_MUL) + N50_W'(OTP_BIAS);
    p50     = n50 * RECIP50;
    q50_nxt = p50[RECIP_SH +: FRAC_BITS];

    // stage 10: select result forms
    f10_pitch = (ctx9_r.func == FUNC_PITCH);
    f10_freq  = (ctx9_r.func != FUNC_PITCH) && (ctx9_r.func != FUNC_OCTAVE);
    if (f10_freq && ctx9_r.val == '0) begin
      out_pitch_nxt = '0;
      out_oct_nxt   = '0;
      out_freq_nxt  = '0;
      out_sat_nxt   = 1'b0;
      out_inv_nxt   = 1'b1;
    end else begin
      out_pitch_nxt = f10_pitch ? ctx9_r.val : {ctx9_r.oct[WORD_W-1:FRAC_BITS], q50_r};
      out_oct_nxt   = ctx9_r.oct;
      out_freq_nxt  = f10_freq ? ctx9_r.val : fexp9_r;
      out_sat_nxt   = ctx9_r.sat;
      out_inv_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1_r   <= ctx1_nxt;
      ctx2_r   <= ctx2_nxt;
      ctx3_r   <= ctx3_nxt;
      ctx4_r   <= ctx4_nxt;
      ctx5_r   <= ctx5_nxt;
      ctx6_r   <= ctx6_nxt;
      ctx7_r   <= ctx7_nxt;
      ctx8_r   <= ctx8_nxt;
      ctx9_r   <= ctx9_nxt;
      q3_r     <= q3_nxt;
      msb2_r   <= msb2_nxt;
      msb3_r   <= msb3_nxt;
      msb4_r   <= msb4_nxt;
      msb5_r   <= msb5_nxt;
      frac3_r  <= frac3_nxt;
      lseg4_r  <= lseg4_nxt;
      lprod5_r <= lprod5_nxt;
      lsum6_r  <= lsum6_nxt;
      lv7_r    <= lv7_nxt;
      fr4_r    <= fr4_nxt;
      eseg5_r  <= eseg5_nxt;
      eprod6_r <= eprod6_nxt;
      mant7_r  <= mant7_nxt;
      fprod8_r <= fprod8_nxt;
      fexp9_r  <= fexp9_nxt;
      q50_r    <= q50_nxt;
      out_pitch_r <= out_pitch_nxt;
      out_oct_r   <= out_oct_nxt;
      out_freq_r  <= out_freq_nxt;
      out_sat_r   <= out_sat_nxt;
      out_inv_r   <= out_inv_nxt;
    end
  end

  assign out_valid        = vld_r[NSTAGE-1];
  assign out_pitch_value  = out_pitch_r;
  assign out_octave_value = out_oct_r;
  assign out_frequency    = out_freq_r;
  assign out_saturated    = out_sat_r;
  assign out_invalid      = out_inv_r;

endmodule

[sv/pfc_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for pitch_format_converter and their bind statement.
// Depends on pfc_pkg for widths.
module pfc_props
  import pfc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_W-1:0]    out_pitch_value,
  input logic [WORD_W-1:0]    out_octave_value,
  input logic [WORD_W-1:0]    out_frequency,
  input logic                 out_saturated,
  input logic                 out_invalid,
  input logic                 cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_value) &&
      $stable(out_octave_value) && $stable(out_frequency))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_pitch_value == '0 && out_octave_value == '0 &&
      out_frequency == '0 && !out_saturated)
    else $error("invalid result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("pipeline not empty after reset");

endmodule

bind pitch_format_converter pfc_props u_pfc_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pitch_value  (out_pitch_value),
  .out_octave_value (out_octave_value),
  .out_frequency    (out_frequency),
  .out_saturated    (out_saturated),
  .out_invalid      (out_invalid),
  .cfg_ready        (cfg_ready)
);
